@@ design/slc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants for the byte-stuffing link codec
// Holds the framing bytes, the command codes, the request structs of both
// channels and the descriptor that the codec core hands to the emitter.
// ----------------------------------------------------------------------------
package slc_pkg;

    // Default handshake header length.
    localparam int HEADER_LEN_DEF = 8;

    // Framing and escape bytes.
    localparam logic [7:0] FRAME_BYTE = 8'hC0;
    localparam logic [7:0] ESC_BYTE   = 8'hDB;
    localparam logic [7:0] ESC_FRAME  = 8'hDC;
    localparam logic [7:0] ESC_ESC    = 8'hDD;

    // Command codes.
    localparam logic [1:0] CMD_LINK  = 2'd0;
    localparam logic [1:0] CMD_SEND  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    // Result destinations.
    localparam logic DEST_HOST = 1'b0;
    localparam logic DEST_LINK = 1'b1;

    // Input request.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } in_item_t;

    // Result request.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       dest;
        logic       status;
        logic       last;
    } out_item_t;

    // Shape of the result burst caused by one input request.
    typedef enum logic [1:0] {
        DESC_NONE,
        DESC_ONE,
        DESC_PAIR,
        DESC_BURST
    } desc_kind_t;

    // Descriptor from the core to the emitter. For a pair, data is the byte
    // that follows the escape byte.
    typedef struct packed {
        desc_kind_t kind;
        logic [7:0] data;
        logic       dest;
        logic       status;
    } desc_t;

    // Header byte loaded at reset for entry i.
    function automatic logic [7:0] default_header_byte(input int i);
        int v;
        v = i + 1;
        return v[7:0];
    endfunction

endpackage
`default_nettype wire

@@ design/slip_link_codec_with_handshake.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slip_link_codec_with_handshake: byte-stuffing link codec with handshake
// Escapes host bytes for the link, unescapes link bytes for the host, and
// runs the header handshake as server (capture and echo) or client.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Request
//  in        input      in_valid / in_ready    in_item_t: cmd, data_byte
//  out       output     out_valid / out_ready  out_item_t: out_byte, dest, status, last
//  cfg       input      cfg_valid / cfg_ready  is_server (1 bit)
//
//  A request is decoded and its state update done in the cycle it is accepted;
//  its first result shows in the result register the next cycle.
//  One request per cycle is taken while each causes at most one result. An
//  escaped send causes two results and a header burst HEADER_LEN + 1, which
//  the result register emits one byte per cycle while out_ready is high.
//  A new request is accepted in the same cycle the final result of the last
//  one is taken. A stalled out channel holds the input side off.
//  Reset returns to awaiting connection with the default header 1..HEADER_LEN.
// ----------------------------------------------------------------------------
module slip_link_codec_with_handshake
    import slc_pkg::*;
#(
    parameter int HEADER_LEN = HEADER_LEN_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_data
);

    localparam int IDX_W = (HEADER_LEN > 1) ? $clog2(HEADER_LEN) : 1;

    logic             accept;
    desc_t            desc;
    logic             rd_sel;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             is_server;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // State update and decode.
    slc_core #(
        .HEADER_LEN(HEADER_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (in_data),
        .rd_sel    (rd_sel),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .desc      (desc),
        .is_server (is_server)
    );

    // Result register and burst sequencing.
    slc_emit #(
        .HEADER_LEN(HEADER_LEN)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .desc      (desc),
        .can_load  (in_ready),
        .rd_sel    (rd_sel),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // No request is taken while a burst still has results to give.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.last) |-> !in_ready)
        else $error("request accepted in the middle of a result burst");

    // An error or refusal result carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status) |-> (out_data.out_byte == 8'h00))
        else $error("status result with a nonzero byte");

    // Host-side results are always single.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.dest == DEST_HOST)) |-> out_data.last)
        else $error("host result not marked last");

    // A client link reset starts its header with a frame byte to the link.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.cmd == CMD_RESET) && !is_server) |=>
        (out_valid && (out_data.out_byte == FRAME_BYTE) && (out_data.dest == DEST_LINK)))
        else $error("client reset did not start a header burst");

endmodule
`default_nettype wire

@@ design/slc_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slc_core: connection state and per-request decode
// Updates the codec state for each accepted request in the cycle it is
// accepted and describes the results that the request causes.
// ----------------------------------------------------------------------------
module slc_core
    import slc_pkg::*;
#(
    parameter int HEADER_LEN = HEADER_LEN_DEF,
    localparam int IDX_W = (HEADER_LEN > 1) ? $clog2(HEADER_LEN) : 1
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_data,
    input  wire logic                     accept,
    input  wire in_item_t                 item,
    input  wire logic                     rd_sel,
    input  wire logic [IDX_W-1:0]         rd_addr,
    output logic      [7:0]               rd_data,
    output desc_t                         desc,
    output logic                          is_server
);

    localparam int CNT_W = $clog2(HEADER_LEN + 1);

    logic                 is_server_reg;
    logic                 awaiting_reg, awaiting_next;
    logic                 error_reg, error_next;
    logic                 active_reg, active_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 esc_reg, esc_next;
    logic [7:0]           store_reg [HEADER_LEN];
    logic                 reload;
    logic                 store_we;
    logic [CNT_W-1:0]     count_inc;
    logic [IDX_W-1:0]     sel_addr;
    logic [7:0]           b;
    logic                 fresh;

    assign is_server = is_server_reg;
    assign b         = item.data_byte;
    assign count_inc = count_reg + 1'b1;

    // One read port: the emitter owns it during a header burst, when no
    // request is accepted; otherwise the client match uses it.
    assign sel_addr = rd_sel ? rd_addr : count_reg[IDX_W-1:0];
    assign rd_data  = store_reg[sel_addr];

    // Next state and result descriptor for the current request.
    always_comb
    begin
        awaiting_next = awaiting_reg;
        error_next    = error_reg;
        active_next   = active_reg;
        count_next    = count_reg;
        esc_next      = esc_reg;
        reload        = 1'b0;
        store_we      = 1'b0;
        fresh         = 1'b1;
        desc          = '{kind: DESC_NONE, data: 8'h00, dest: DEST_HOST, status: 1'b0};

        unique case (item.cmd)
            CMD_RESET:
            begin
                awaiting_next = 1'b1;
                error_next    = 1'b0;
                active_next   = 1'b0;
                count_next    = '0;
                esc_next      = 1'b0;
                if (!is_server_reg)
                begin
                    reload = 1'b1;
                    desc   = '{kind: DESC_BURST, data: FRAME_BYTE, dest: DEST_LINK,
                               status: 1'b0};
                end
            end
            CMD_SEND:
            begin
                if (error_reg)
                    desc = '{kind: DESC_ONE, data: 8'h00, dest: DEST_LINK, status: 1'b1};
                else if (b == FRAME_BYTE)
                    desc = '{kind: DESC_PAIR, data: ESC_FRAME, dest: DEST_LINK, status: 1'b0};
                else if (b == ESC_BYTE)
                    desc = '{kind: DESC_PAIR, data: ESC_ESC, dest: DEST_LINK, status: 1'b0};
                else
                    desc = '{kind: DESC_ONE, data: b, dest: DEST_LINK, status: 1'b0};
            end
            CMD_LINK:
            begin
                if (error_reg)
                begin
                    desc = '{kind: DESC_ONE, data: 8'h00, dest: DEST_HOST, status: 1'b1};
                end
                else if (awaiting_reg)
                begin
                    // Handshake: a frame byte always restarts the header.
                    if (b == FRAME_BYTE)
                    begin
                        active_next = 1'b1;
                        count_next  = '0;
                    end
                    else if (active_reg && (count_reg < CNT_W'(HEADER_LEN)))
                    begin
                        if (is_server_reg || (rd_data == b))
                        begin
                            store_we = is_server_reg;
                            if (count_inc == CNT_W'(HEADER_LEN))
                            begin
                                awaiting_next = 1'b0;
                                active_next   = 1'b0;
                                count_next    = '0;
                                esc_next      = 1'b0;
                                if (is_server_reg)
                                    desc = '{kind: DESC_BURST, data: FRAME_BYTE,
                                             dest: DEST_LINK, status: 1'b0};
                            end
                            else
                            begin
                                count_next = count_inc;
                            end
                        end
                        else
                        begin
                            // The client saw a header byte that does not match.
                            active_next = 1'b0;
                            count_next  = '0;
                        end
                    end
                end
                else
                begin
                    // Connected: unescape link data.
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        if (b == ESC_FRAME)
                        begin
                            fresh = 1'b0;
                            desc  = '{kind: DESC_ONE, data: FRAME_BYTE, dest: DEST_HOST,
                                      status: 1'b0};
                        end
                        else if (b == ESC_ESC)
                        begin
                            fresh = 1'b0;
                            desc  = '{kind: DESC_ONE, data: ESC_BYTE, dest: DEST_HOST,
                                      status: 1'b0};
                        end
                        else if ((b != ESC_BYTE) && (b != FRAME_BYTE))
                        begin
                            fresh         = 1'b0;
                            error_next    = 1'b1;
                            awaiting_next = 1'b1;
                            active_next   = 1'b0;
                            count_next    = '0;
                            desc          = '{kind: DESC_ONE, data: 8'h00, dest: DEST_HOST,
                                              status: 1'b1};
                        end
                    end
                    // An escape followed by an escape or frame byte is dropped
                    // and the byte is handled afresh.
                    if (fresh)
                    begin
                        if (b == ESC_BYTE)
                        begin
                            esc_next = 1'b1;
                        end
                        else if (b == FRAME_BYTE)
                        begin
                            error_next    = 1'b1;
                            awaiting_next = 1'b1;
                            active_next   = 1'b0;
                            count_next    = '0;
                            esc_next      = 1'b0;
                            desc          = '{kind: DESC_ONE, data: 8'h00, dest: DEST_HOST,
                                              status: 1'b1};
                        end
                        else
                        begin
                            desc = '{kind: DESC_ONE, data: b, dest: DEST_HOST, status: 1'b0};
                        end
                    end
                end
            end
            default:
            begin
                // Unknown command: no effect.
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_server_reg <= 1'b0;
            awaiting_reg  <= 1'b1;
            error_reg     <= 1'b0;
            active_reg    <= 1'b0;
            count_reg     <= '0;
            esc_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                is_server_reg <= cfg_data;
            if (accept)
            begin
                awaiting_reg <= awaiting_next;
                error_reg    <= error_next;
                active_reg   <= active_next;
                count_reg    <= count_next;
                esc_reg      <= esc_next;
            end
        end
    end

    // Header store: reloaded by a client reset, written by a server capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HEADER_LEN; i++)
                store_reg[i] <= default_header_byte(i);
        end
        else if (accept && reload)
        begin
            for (int i = 0; i < HEADER_LEN; i++)
                store_reg[i] <= default_header_byte(i);
        end
        else if (accept && store_we)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= b;
        end
    end

endmodule
`default_nettype wire

@@ design/slc_emit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slc_emit: result register and burst sequencer
// Turns a descriptor into one, two or HEADER_LEN + 1 result requests and
// holds each one until the downstream side takes it.
// ----------------------------------------------------------------------------
module slc_emit
    import slc_pkg::*;
#(
    parameter int HEADER_LEN = HEADER_LEN_DEF,
    localparam int IDX_W = (HEADER_LEN > 1) ? $clog2(HEADER_LEN) : 1
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire desc_t                    desc,
    output logic                          can_load,
    output logic                          rd_sel,
    output logic      [IDX_W-1:0]         rd_addr,
    input  wire logic [7:0]               rd_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output out_item_t                     out_data
);

    logic             valid_reg, valid_next;
    logic             last_reg, last_next;
    desc_kind_t       mode_reg, mode_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       byte_reg, byte_next;
    logic [7:0]       second_reg, second_next;
    logic             dest_reg, dest_next;
    logic             status_reg, status_next;
    logic             advance;

    // The store is read only while further header bytes remain; on the final
    // result a new request may be taken and needs the read port.
    assign advance   = valid_reg && out_ready;
    assign can_load  = !valid_reg || (out_ready && last_reg);
    assign rd_sel    = valid_reg && (mode_reg == DESC_BURST) && !last_reg;
    assign rd_addr   = idx_reg;
    assign out_valid = valid_reg;
    assign out_data  = '{out_byte: byte_reg, dest: dest_reg, status: status_reg,
                         last: last_reg};

    // Step through the burst, or load a fresh descriptor.
    always_comb
    begin
        valid_next  = valid_reg;
        last_next   = last_reg;
        mode_next   = mode_reg;
        idx_next    = idx_reg;
        byte_next   = byte_reg;
        second_next = second_reg;
        dest_next   = dest_reg;
        status_next = status_reg;

        if (advance && !last_reg)
        begin
            if (mode_reg == DESC_PAIR)
            begin
                byte_next = second_reg;
                last_next = 1'b1;
            end
            else
            begin
                byte_next = rd_data;
                last_next = (idx_reg == IDX_W'(HEADER_LEN - 1));
                idx_next  = idx_reg + 1'b1;
            end
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end

        if (load && (desc.kind != DESC_NONE))
        begin
            valid_next  = 1'b1;
            mode_next   = desc.kind;
            dest_next   = desc.dest;
            status_next = desc.status;
            unique case (desc.kind)
                DESC_PAIR:
                begin
                    byte_next   = ESC_BYTE;
                    second_next = desc.data;
                    last_next   = 1'b0;
                end
                DESC_BURST:
                begin
                    byte_next = FRAME_BYTE;
                    idx_next  = '0;
                    last_next = 1'b0;
                end
                default:
                begin
                    byte_next = desc.data;
                    last_next = 1'b1;
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            mode_reg  <= DESC_NONE;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        second_reg <= second_next;
        dest_reg   <= dest_next;
        status_reg <= status_next;
    end

endmodule
`default_nettype wire
